// ----- src/pvsa_pkg.sv -----
package pvsa_pkg;

   // field and state widths
   localparam int unsigned SETPOINT_W = 16;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned SUM_W      = 20;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned TRIES_W    = 8;
   localparam int unsigned PPR_W      = 16;
   localparam int unsigned BAND_W     = 16;
   localparam int unsigned STEPS_W    = 16;
   localparam int unsigned STATUS_W   = 3;

   // error between downstream average and target
   localparam int unsigned DIFF_W = 18;
   localparam int unsigned ERR_W  = 17;

   // step scaling: steps = err * ppr / 500, capped at ppr once err reaches 500
   localparam logic [ERR_W-1:0] STEP_CAP_ERR = 17'd500;
   localparam int unsigned FINE_ERR_W = 9;
   localparam int unsigned PROD_W     = FINE_ERR_W + PPR_W;
   // ceil(2^34 / 500), exact for every product below 2^25
   localparam int unsigned STEP_SHIFT   = 34;
   localparam int unsigned STEP_RECIP_W = 26;
   localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 26'd34359739;
   localparam int unsigned STEP_FULL_W = PROD_W + STEP_RECIP_W;

   // register reset values
   localparam logic [PPR_W-1:0]   PPR_RESET   = 16'd2000;
   localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd75;
   localparam logic [TRIES_W-1:0] TRIES_RESET = 8'd5;

   // command codes
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_MOVE      = 3'd0,
      ST_IN_BAND   = 3'd1,
      ST_TRIES_OUT = 3'd2,
      ST_UP_LOW    = 3'd3,
      ST_DOWN_LOW  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_PPR   = 2'd0,
      REG_BAND  = 2'd1,
      REG_TRIES = 2'd2
   } reg_index_type;

   // evaluation result as it leaves the state stage
   typedef struct packed {
      status_type                   status;
      logic                         done;
      logic                         reverse;
      logic                         cap;
      logic [FINE_ERR_W-1:0]        err;
      logic signed [SAMPLE_W-1:0]   up_avg;
      logic signed [SAMPLE_W-1:0]   down_avg;
   } eval_type;

   // after the error times pulses product
   typedef struct packed {
      status_type                   status;
      logic                         done;
      logic                         reverse;
      logic                         cap;
      logic [PROD_W-1:0]            product;
      logic signed [SAMPLE_W-1:0]   up_avg;
      logic signed [SAMPLE_W-1:0]   down_avg;
   } scale_type;

   // final result
   typedef struct packed {
      status_type                   status;
      logic                         done;
      logic                         reverse;
      logic [STEPS_W-1:0]           steps;
      logic signed [SAMPLE_W-1:0]   up_avg;
      logic signed [SAMPLE_W-1:0]   down_avg;
   } result_type;

endpackage

// ----- src/pilot_valve_step_adjuster_top.sv -----
// Pilot valve step adjuster.
// Input stream (req_): tuser carries the command, 0 start with a new setpoint,
// 1 one upstream/downstream sample pair; tdata carries setpoint and samples.
// A start with a positive setpoint opens or restarts a session; after every
// SAMPLES_PER_CHECK sample pairs the averages are evaluated and one result
// transaction leaves on the rsp_ stream: a move (direction and steps) or the
// end of the session with its reason. Starts, partial rounds and samples
// outside a session give no result.
// Throughput: one input transaction per cycle, unless an evaluating item
// waits in the input register for stage 1. The session state (tries, sums,
// sample count) is updated as an item leaves the input register; the result
// then passes the evaluation, product and output registers to rsp_tvalid.
// Each stage holds its own valid bit; a stalled receiver fills the stages one
// by one, and req_tready falls only when the input register cannot move on.
// Reset clears the session, the pipeline and loads the register defaults
// (2000 pulses per rev, band 75, 5 tries). The csr_ APB port writes and reads
// the three registers at byte addresses 0, 4 and 8; pready is always high.
module pilot_valve_step_adjuster_top
   import pvsa_pkg::*;
#(
   parameter int unsigned SAMPLES_PER_CHECK = 3
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // setpoint, upstream_sample, downstream_sample
   input  logic        req_tuser,  // cmd
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // reverse, steps, upstream_avg, downstream_avg, zero fill
   output logic [3:0]  rsp_tuser,  // status, session_done
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // reciprocal for the sample average, exact for magnitudes below 2^19
   localparam int unsigned MAG_W       = SUM_W - 1;
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [63:0] RECIP_FULL  =
      ((64'd1 << RECIP_SHIFT) + 64'(SAMPLES_PER_CHECK) - 64'd1) / 64'(SAMPLES_PER_CHECK);
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_FULL[RECIP_W-1:0];
   localparam int unsigned AVG_PROD_W = MAG_W + RECIP_W;
   localparam logic [COUNT_W-1:0] ROUND_LEN = COUNT_W'(SAMPLES_PER_CHECK);

   // sum divided by the round length, truncated toward zero
   function automatic logic signed [SAMPLE_W-1:0] avg_of(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0]      mag;
      logic [AVG_PROD_W-1:0] prod;
      logic [SUM_W-1:0]      quot;
      mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      prod = AVG_PROD_W'(mag[MAG_W-1:0]) * AVG_PROD_W'(RECIP_MULT);
      quot = prod[RECIP_SHIFT +: SUM_W];
      quot = sum[SUM_W-1] ? (~quot + 1'b1) : quot;
      return signed'(quot[SAMPLE_W-1:0]);
   endfunction

   // configuration registers
   logic [PPR_W-1:0]   ppr_ff;
   logic [BAND_W-1:0]  band_ff;
   logic [TRIES_W-1:0] max_tries_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   // session state
   logic                       active_ff, active_in;
   logic signed [SETPOINT_W-1:0] target_ff, target_in;
   logic [TRIES_W-1:0]         tries_ff, tries_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]    up_sum_ff, up_sum_in;
   logic signed [SUM_W-1:0]    down_sum_ff, down_sum_in;

   // input register
   logic                         s0_valid_ff, s0_valid_in;
   logic                         s0_cmd_ff;
   logic signed [SETPOINT_W-1:0] s0_setpoint_ff;
   logic signed [SAMPLE_W-1:0]   s0_up_ff;
   logic signed [SAMPLE_W-1:0]   s0_down_ff;
   logic                         s0_ready, s0_fire;

   // later stages
   logic       s1_valid_ff, s1_valid_in, s1_ready;
   eval_type   s1_ff, s1_in;
   logic       s2_valid_ff, s2_valid_in, s2_ready;
   scale_type  s2_ff, s2_in;
   logic       s3_valid_ff, s3_valid_in, s3_ready;
   result_type s3_ff, s3_in;

   // evaluation signals
   logic                       sample_go, eval_hit;
   logic [COUNT_W-1:0]         count_next;
   logic signed [SUM_W-1:0]    up_sum_next, down_sum_next;
   logic signed [SAMPLE_W-1:0] up_avg, down_avg;
   logic signed [DIFF_W-1:0]   diff;
   logic [ERR_W-1:0]           err;
   status_type                 status;
   logic [STEP_FULL_W-1:0]     step_full;

   // apb port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_PPR:   csr_prdata = 32'(ppr_ff);
         REG_BAND:  csr_prdata = 32'(band_ff);
         REG_TRIES: csr_prdata = 32'(max_tries_ff);
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff       <= PPR_RESET;
         band_ff      <= BAND_RESET;
         max_tries_ff <= TRIES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PPR:   ppr_ff       <= csr_pwdata[PPR_W-1:0];
            REG_BAND:  band_ff      <= csr_pwdata[BAND_W-1:0];
            REG_TRIES: max_tries_ff <= csr_pwdata[TRIES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // round accumulation and evaluation of the item in the input register
   always_comb begin
      sample_go     = s0_valid_ff && (s0_cmd_ff == CMD_SAMPLE) && active_ff;
      count_next    = count_ff + 1'b1;
      eval_hit      = sample_go && (count_next == ROUND_LEN);
      up_sum_next   = up_sum_ff + SUM_W'(s0_up_ff);
      down_sum_next = down_sum_ff + SUM_W'(s0_down_ff);
      up_avg        = avg_of(up_sum_next);
      down_avg      = avg_of(down_sum_next);
      diff          = DIFF_W'(down_avg) - DIFF_W'(target_ff);
      err           = diff[DIFF_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
      if (err < ERR_W'(band_ff)) begin
         status = ST_IN_BAND;
      end else if (tries_ff >= max_tries_ff) begin
         status = ST_TRIES_OUT;
      end else if (up_avg <= 0) begin
         status = ST_UP_LOW;
      end else if (down_avg <= 0) begin
         status = ST_DOWN_LOW;
      end else begin
         status = ST_MOVE;
      end
   end

   // input register handshake: items without a result never wait on stage 1
   assign s0_fire    = s0_valid_ff && (!eval_hit || s1_ready);
   assign s0_ready   = !s0_valid_ff || s0_fire;
   assign req_tready = s0_ready;
   assign s0_valid_in = s0_ready ? req_tvalid : s0_valid_ff;

   // session state update
   always_comb begin
      active_in   = active_ff;
      target_in   = target_ff;
      tries_in    = tries_ff;
      count_in    = count_ff;
      up_sum_in   = up_sum_ff;
      down_sum_in = down_sum_ff;
      if (s0_fire) begin
         if (s0_cmd_ff == CMD_START) begin
            if (s0_setpoint_ff > 0) begin
               active_in   = 1'b1;
               target_in   = s0_setpoint_ff;
               tries_in    = '0;
               count_in    = '0;
               up_sum_in   = '0;
               down_sum_in = '0;
            end
         end else if (sample_go) begin
            if (eval_hit) begin
               count_in    = '0;
               up_sum_in   = '0;
               down_sum_in = '0;
               if (status == ST_MOVE) begin
                  tries_in = tries_ff + 1'b1;
               end else begin
                  active_in = 1'b0;
               end
            end else begin
               count_in    = count_next;
               up_sum_in   = up_sum_next;
               down_sum_in = down_sum_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         target_ff   <= '0;
         tries_ff    <= '0;
         count_ff    <= '0;
         up_sum_ff   <= '0;
         down_sum_ff <= '0;
         s0_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         target_ff   <= target_in;
         tries_ff    <= tries_in;
         count_ff    <= count_in;
         up_sum_ff   <= up_sum_in;
         down_sum_ff <= down_sum_in;
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s0_ready) begin
         s0_cmd_ff      <= req_tuser;
         s0_setpoint_ff <= signed'(req_tdata[15:0]);
         s0_up_ff       <= signed'(req_tdata[31:16]);
         s0_down_ff     <= signed'(req_tdata[47:32]);
      end
   end

   // stage 1: evaluation result
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign s1_valid_in = s1_ready ? (s0_fire && eval_hit) : s1_valid_ff;

   always_comb begin
      s1_in.status   = status;
      s1_in.done     = (status != ST_MOVE);
      s1_in.reverse  = (status == ST_MOVE) && !diff[DIFF_W-1];
      s1_in.cap      = (status == ST_MOVE) && (err >= STEP_CAP_ERR);
      s1_in.err      = (status == ST_MOVE) ? err[FINE_ERR_W-1:0] : '0;
      s1_in.up_avg   = up_avg;
      s1_in.down_avg = down_avg;
   end

   // stage 2: error times pulses per rev
   assign s2_ready    = !s2_valid_ff || s3_ready;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s2_in.status   = s1_ff.status;
      s2_in.done     = s1_ff.done;
      s2_in.reverse  = s1_ff.reverse;
      s2_in.cap      = s1_ff.cap;
      s2_in.product  = PROD_W'(s1_ff.err) * PROD_W'(ppr_ff);
      s2_in.up_avg   = s1_ff.up_avg;
      s2_in.down_avg = s1_ff.down_avg;
   end

   // stage 3: divide by 500 through the reciprocal, or take the cap
   assign s3_ready    = !s3_valid_ff || rsp_tready;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_comb begin
      step_full      = STEP_FULL_W'(s2_ff.product) * STEP_FULL_W'(STEP_RECIP);
      s3_in.status   = s2_ff.status;
      s3_in.done     = s2_ff.done;
      s3_in.reverse  = s2_ff.reverse;
      s3_in.steps    = s2_ff.cap ? ppr_ff : step_full[STEP_SHIFT +: STEPS_W];
      s3_in.up_avg   = s2_ff.up_avg;
      s3_in.down_avg = s2_ff.down_avg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

   // result stream
   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tuser  = {s3_ff.done, s3_ff.status};
   assign rsp_tdata  = {7'd0, s3_ff.down_avg, s3_ff.up_avg, s3_ff.steps, s3_ff.reverse};

   // an evaluation that ends the session leaves the session inactive
   a_end_clears_session: assert property (@(posedge clock) disable iff (reset)
      s0_fire && eval_hit && (status != ST_MOVE) |=> !active_ff)
      else $error("session still active after an ending evaluation");

   // a move counts exactly one try
   a_move_counts_try: assert property (@(posedge clock) disable iff (reset)
      s0_fire && eval_hit && (status == ST_MOVE) |=> tries_ff == $past(tries_ff) + 1'b1)
      else $error("try count not advanced by a move");

   // a capped move leaves with one full revolution of steps
   a_cap_steps: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s3_ready && s2_ff.cap |=> s3_valid_ff && (s3_ff.steps == ppr_ff))
      else $error("capped move without full revolution steps");

   // a stage 1 entry holds while stage 2 cannot take it
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_ff))
      else $error("stage 1 entry lost during stall");

endmodule

// ----- tb/pvsa_result_checker.sv -----
`timescale 1ns / 100ps
module pvsa_result_checker
   import pvsa_pkg::*;
#(
   parameter int unsigned SAMPLES_PER_CHECK = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,  // setpoint, upstream_sample, downstream_sample
   input  logic        req_tuser,  // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,  // reverse, steps, upstream_avg, downstream_avg, zero fill
   input  logic [3:0]  rsp_tuser,  // status, session_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);

   // register copies
   logic [PPR_W-1:0]   pulses_per_rev;
   logic [BAND_W-1:0]  band_limit;
   logic [TRIES_W-1:0] tries_limit;

   // session state
   logic                    session_open;
   logic signed [15:0]      target_sp;
   logic [TRIES_W-1:0]      tries_used;
   logic [COUNT_W-1:0]      pairs_taken;
   logic signed [SUM_W-1:0] up_acc;
   logic signed [SUM_W-1:0] down_acc;

   result_type evaluations_due[$];
   int         mismatches = 0;

   // advance the session by one input transaction, queue any evaluation it causes
   task automatic evaluate_item(input logic cmd, input logic [47:0] data);
      logic signed [15:0] sp;
      logic signed [15:0] up_s;
      logic signed [15:0] down_s;
      int up_total;
      int down_total;
      int up_avg;
      int down_avg;
      int tgt;
      int diff;
      int err;
      int band_int;
      int per_round;
      longint scaled;
      result_type eval;
      sp = data[15:0];
      up_s = data[31:16];
      down_s = data[47:32];
      per_round = SAMPLES_PER_CHECK;
      if (cmd == CMD_START) begin
         // nonpositive setpoint leaves everything as it is
         if (sp > 0) begin
            target_sp = sp;
            tries_used = '0;
            session_open = 1'b1;
            pairs_taken = '0;
            up_acc = '0;
            down_acc = '0;
         end
      end else if (session_open) begin
         up_acc = up_acc + up_s;
         down_acc = down_acc + down_s;
         pairs_taken = pairs_taken + 1'b1;
         if (pairs_taken >= per_round) begin
            up_total = int'(up_acc);
            down_total = int'(down_acc);
            up_avg = up_total / per_round;
            down_avg = down_total / per_round;
            tgt = int'(target_sp);
            diff = down_avg - tgt;
            err = (diff < 0) ? -diff : diff;
            band_int = int'(band_limit);
            pairs_taken = '0;
            up_acc = '0;
            down_acc = '0;
            eval.reverse = 1'b0;
            eval.steps = '0;
            scaled = 0;
            // checks in priority order
            if (err < band_int) begin
               eval.status = ST_IN_BAND;
            end else if (tries_used >= tries_limit) begin
               eval.status = ST_TRIES_OUT;
            end else if (up_avg <= 0) begin
               eval.status = ST_UP_LOW;
            end else if (down_avg <= 0) begin
               eval.status = ST_DOWN_LOW;
            end else begin
               eval.status = ST_MOVE;
               eval.reverse = (down_avg < tgt) ? 1'b0 : 1'b1;
               scaled = longint'(err) * longint'(pulses_per_rev) / 500;
               if (scaled > longint'(pulses_per_rev)) begin
                  scaled = longint'(pulses_per_rev);
               end
               tries_used = tries_used + 1'b1;
            end
            if (eval.status != ST_MOVE) begin
               session_open = 1'b0;
            end
            eval.done = ~session_open;
            eval.steps = scaled[STEPS_W-1:0];
            eval.up_avg = up_avg[15:0];
            eval.down_avg = down_avg[15:0];
            evaluations_due.push_back(eval);
         end
      end
   endtask

   // compare one result transaction with the oldest evaluation due
   task automatic check_result();
      result_type got;
      result_type due;
      got.status = status_type'(rsp_tuser[2:0]);
      got.done = rsp_tuser[3];
      got.reverse = rsp_tdata[0];
      got.steps = rsp_tdata[16:1];
      got.up_avg = rsp_tdata[32:17];
      got.down_avg = rsp_tdata[48:33];
      if (evaluations_due.size() == 0) begin
         if (mismatches < 10) begin
            $display("unexpected result: status %0d done %0b rev %0b steps %0d up %0d down %0d",
                     got.status, got.done, got.reverse, got.steps, got.up_avg, got.down_avg);
         end
         mismatches++;
      end else begin
         due = evaluations_due.pop_front();
         if (got.status !== due.status || got.done !== due.done ||
             got.reverse !== due.reverse || got.steps !== due.steps ||
             got.up_avg !== due.up_avg || got.down_avg !== due.down_avg) begin
            if (mismatches < 10) begin
               $display("mismatch: expected status %0d done %0b rev %0b steps %0d up %0d down %0d",
                        due.status, due.done, due.reverse, due.steps, due.up_avg,
                        due.down_avg);
               $display("          actual   status %0d done %0b rev %0b steps %0d up %0d down %0d",
                        got.status, got.done, got.reverse, got.steps, got.up_avg,
                        got.down_avg);
            end
            mismatches++;
         end
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         pulses_per_rev <= PPR_RESET;
         band_limit <= BAND_RESET;
         tries_limit <= TRIES_RESET;
         session_open = 1'b0;
         target_sp = '0;
         tries_used = '0;
         pairs_taken = '0;
         up_acc = '0;
         down_acc = '0;
         evaluations_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
         if (req_tvalid && req_tready) begin
            evaluate_item(req_tuser, req_tdata);
         end
         // register writes take effect for later transactions
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_PPR: begin
                  pulses_per_rev <= csr_pwdata[PPR_W-1:0];
               end
               REG_BAND: begin
                  band_limit <= csr_pwdata[BAND_W-1:0];
               end
               REG_TRIES: begin
                  tries_limit <= csr_pwdata[TRIES_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      fail_count <= mismatches;
      pending_count <= evaluations_due.size();
   end

endmodule

// ----- tb/tb_pilot_valve_step_adjuster_top.sv -----
`timescale 1ns / 100ps
module tb_pilot_valve_step_adjuster_top
   import pvsa_pkg::*;
();

   localparam int unsigned SAMPLES_PER_CHECK = 3;
   localparam int HOLD_CYCLES = 200;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int PHASES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // setpoint, upstream_sample, downstream_sample
   logic        req_tuser = 1'b0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;  // reverse, steps, upstream_avg, downstream_avg, zero fill
   logic [3:0]  rsp_tuser;  // status, session_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_count;

   bit sender_burst = 1'b0;
   bit receiver_burst = 1'b0;
   bit pressure_phase = 1'b0;
   bit hold_request = 1'b0;
   bit hold_served = 1'b0;
   int session_items = 0;
   int cur_band = 75;

   always #2 clock = ~clock;

   pilot_valve_step_adjuster_top #(
      .SAMPLES_PER_CHECK(SAMPLES_PER_CHECK)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pvsa_result_checker #(
      .SAMPLES_PER_CHECK(SAMPLES_PER_CHECK)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // clamp to the 16 bit signed range
   function automatic logic [15:0] sat16(input int v);
      if (v > 32767) begin
         return 16'h7fff;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // offer one transaction after a random gap, return at the edge that takes it
   task automatic send_item(input logic cmd, input logic [47:0] data);
      int gap;
      if ($urandom_range(0, 23) == 0) begin
         sender_burst = ~sender_burst;
      end
      gap = (sender_burst || pressure_phase) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_start(input int sp);
      logic [31:0] filler;
      filler = $urandom;
      send_item(CMD_START, {filler, sat16(sp)});
   endtask

   task automatic send_pair(input int up, input int down);
      logic [15:0] filler;
      filler = 16'($urandom_range(0, 65535));
      send_item(CMD_SAMPLE, {sat16(down), sat16(up), filler});
   endtask

   // register write: setup phase, access phase, then idle
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] ppr, input logic [15:0] band,
                                input logic [7:0] tries);
      logic [31:0] noise;
      noise = $urandom;
      csr_write(REG_PPR, {noise[31:16], ppr});
      csr_write(REG_BAND, {noise[15:0], band});
      csr_write(REG_TRIES, {noise[23:0], tries});
      cur_band = int'(band);
   endtask

   // let every evaluation drain, then the pipeline empty out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one session: a start, then rounds of sample pairs with random content
   task automatic run_session();
      int sp;
      int rounds;
      int kind;
      int base_up;
      int base_down;
      int offset;
      int lim;
      int jit_up;
      int jit_down;
      case ($urandom_range(0, 7))
         0: sp = 1;
         1: sp = 32767;
         default: sp = $urandom_range(1, 20000);
      endcase
      send_start(sp);
      session_items++;
      rounds = $urandom_range(1, 7);
      repeat (rounds) begin
         kind = $urandom_range(0, 11);
         base_up = $urandom_range(1, 32767);
         lim = (cur_band > 2000) ? 2000 : cur_band;
         case (kind)
            0, 1: begin
               // near the band edge
               offset = $urandom_range(0, 2 * lim + 4);
               base_down = sp + offset - lim - 2;
            end
            2: begin
               base_up = $urandom_range(0, 32768);
               base_up = -base_up;
               offset = $urandom_range(0, 4000);
               base_down = sp + offset - 2000;
            end
            3: begin
               base_down = $urandom_range(0, 32768);
               base_down = -base_down;
            end
            default: begin
               offset = $urandom_range(0, 6000);
               base_down = sp + offset - 3000;
            end
         endcase
         repeat (SAMPLES_PER_CHECK) begin
            jit_up = $urandom_range(0, 4);
            jit_down = $urandom_range(0, 4);
            send_pair(base_up + jit_up - 2, base_down + jit_down - 2);
            session_items++;
         end
         // broken sequences: ignored start or restart mid-session
         case ($urandom_range(0, 24))
            0: begin
               offset = $urandom_range(0, 32768);
               send_start(-offset);
            end
            1: begin
               send_start($urandom_range(1, 32767));
               session_items++;
            end
            default: begin
            end
         endcase
      end
   endtask

   // pure noise: every bit of every field at random
   task automatic send_noise();
      logic [47:0] data;
      data = 48'({$urandom, $urandom});
      send_item(logic'($urandom_range(0, 1)), data);
   endtask

   // receiver: random stalls, burst stretches and one long hold-off
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end
         if ($urandom_range(0, 15) == 0) begin
            receiver_burst = ~receiver_burst;
         end
         stall = receiver_burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // main stimulus and verdict
   initial begin
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset register values
      send_pair(-1, -1);                 // sample with no session
      send_start(0);                     // nonpositive setpoint
      send_start(-32768);
      send_start(32767);
      repeat (3) send_pair(32767, 32767); // in band
      send_start(1);
      repeat (3) send_pair(-32768, 2000); // upstream low
      send_start(10000);
      send_pair(100, -1);
      send_pair(100, -1);
      send_pair(100, 0);                 // average truncates to zero, downstream low
      send_start(10000);
      send_pair(50, 9000);
      send_pair(50, 9000);               // partial round
      send_start(5000);                  // restart drops the partial round
      send_pair(5, 4000);
      send_pair(5, 4001);
      send_pair(5, 4002);                // forward move, steps capped
      send_pair(1, 5000);
      send_pair(1, 5000);
      send_pair(1, 5001);                // in band after truncation
      wait_drained();

      // random phases, each with its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_registers(16'd0, 16'd0, 8'd255);
            1: set_registers(16'd65535, 16'd0, 8'd0);
            2: set_registers(16'd1, 16'd65535, 8'd1);
            3: set_registers(16'd2000, 16'd75, 8'd5);
            default: set_registers(16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 400)),
                                   8'($urandom_range(0, 8)));
         endcase
         if (phase == 3) begin
            pressure_phase = 1'b1;
            hold_request = 1'b1;
         end
         while (session_items < (phase + 1) * ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               send_noise();
            end else begin
               run_session();
            end
            if (pressure_phase && hold_served) begin
               pressure_phase = 1'b0;
            end
         end
         pressure_phase = 1'b0;
         wait_drained();
      end

      // final drain with a limit
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
